/* sv/ols_pkg.sv */
// Shared types, codes and sizes for the ordered list store.
`default_nettype none

package ols_pkg;

  localparam int OLS_CAPACITY = 16;

  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int LEN_W = 9;
  localparam int OP_W  = 3;
  localparam int ST_W  = 3;

  // request codes
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH   = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_OOB      = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // walk index load select
  localparam logic [1:0] IDX_ZERO = 2'd0;
  localparam logic [1:0] IDX_POS  = 2'd1;
  localparam logic [1:0] IDX_TOP  = 2'd2;

  typedef struct packed {
    logic            load;
    logic            set_idx;
    logic [1:0]      idx_sel;
    logic            rd_en;
    logic            wr_val;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            set_st;
    logic [ST_W-1:0] st;
    logic            set_found;
  } ols_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_oob;
    logic            at_tail;
    logic            full;
    logic            empty;
    logic            del_oob;
    logic            at_pos;
    logic            at_last;
    logic            scan_end;
    logic            cmp_vld;
    logic            hit;
  } ols_sts_t;

endpackage

`default_nettype wire

/* sv/ordered_list_store.sv */
// Top level of the ordered list store: controller plus datapath.
`default_nettype none

// Bounded ordered list of signed 32-bit values, up to CAPACITY entries, one
// request per item: insert at a position or at the tail, delete at a position
// or at the tail, and search for the first entry equal to a key. An item is
// taken on a clock edge with start high and busy low; busy then stays high
// until its result has been shown. The result appears on the out_ ports for
// exactly one cycle, flagged by out_valid, and must be taken then: there is
// no way to hold it off. Entries live in a single-port-style memory (one
// registered read and one write per cycle), so shifting or scanning moves
// one entry a cycle. No new item is taken until the last result has been
// shown. An insert ahead of the tail moves each entry from the end back to
// the position up by one; a delete moves each entry after the position
// down by one; a search scans from the head to the first match or the end.
// Entries come out of reset undefined and are read only below the length.
module ordered_list_store #(
  parameter int CAPACITY = ols_pkg::OLS_CAPACITY
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic        [ols_pkg::OP_W-1:0]  in_op,
  input  wire logic signed [ols_pkg::VAL_W-1:0] in_value,
  input  wire logic        [ols_pkg::POS_W-1:0] in_position,
  output logic                                  out_valid,
  output logic             [ols_pkg::ST_W-1:0]  out_status,
  output logic signed      [ols_pkg::VAL_W-1:0] out_removed_value,
  output logic             [ols_pkg::POS_W-1:0] out_found_index,
  output logic             [ols_pkg::LEN_W-1:0] out_length
);
  import ols_pkg::*;

  // command and status between sequencer and datapath
  ols_cmd_t cmd;
  ols_sts_t sts;

  // sequence each item: check bounds, walk the memory, then strobe the result
  ols_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold the entries, the length and the result fields
  ols_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_op),
    .in_value          (in_value),
    .in_position       (in_position),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_found_index   (out_found_index),
    .out_length        (out_length)
  );

endmodule

`default_nettype wire

/* sv/ols_dp.sv */
// Datapath of the ordered list store: entry memory, walk index, pending move and result registers.
`default_nettype none

module ols_dp #(
  parameter int CAPACITY = ols_pkg::OLS_CAPACITY
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic        [ols_pkg::OP_W-1:0]     in_op,
  input  wire logic signed [ols_pkg::VAL_W-1:0]    in_value,
  input  wire logic        [ols_pkg::POS_W-1:0]    in_position,
  input  wire ols_pkg::ols_cmd_t                   cmd,
  output ols_pkg::ols_sts_t                        sts,
  output logic             [ols_pkg::ST_W-1:0]     out_status,
  output logic signed      [ols_pkg::VAL_W-1:0]    out_removed_value,
  output logic             [ols_pkg::POS_W-1:0]    out_found_index,
  output logic             [ols_pkg::LEN_W-1:0]    out_length
);
  import ols_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] val_r;
  logic [LEN_W-1:0] pos_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [VAL_W-1:0] rdata_r;
  logic             pend_r;
  logic             pend_cap_r;
  logic [AW-1:0]    pend_addr_r;
  logic             cmp_vld_r;
  logic [AW-1:0]    cmp_addr_r;
  logic [VAL_W-1:0] removed_r;
  logic [POS_W-1:0] found_r;
  logic [ST_W-1:0]  st_r;
  logic [LEN_W-1:0] pos_load;
  logic [LEN_W-1:0] count_ext;
  logic [LEN_W-1:0] idx_ext;
  logic             is_ins;
  logic             is_del;

  assign is_ins    = (op_r == OP_INS_POS) || (op_r == OP_INS_TAIL);
  assign is_del    = (op_r == OP_DEL_POS) || (op_r == OP_DEL_TAIL);
  assign count_ext = LEN_W'(count_r);
  assign idx_ext   = LEN_W'(idx_r);

  always_comb begin
    case (in_op)
      OP_INS_TAIL: pos_load = LEN_W'(count_r);
      OP_DEL_TAIL: pos_load = LEN_W'(count_r) - LEN_W'(1);
      default:     pos_load = {1'b0, in_position};
    endcase
  end

  always_comb begin
    sts.op       = op_r;
    sts.ins_oob  = pos_r > count_ext;
    sts.at_tail  = pos_r == count_ext;
    sts.full     = count_r == CAP_C;
    sts.empty    = count_r == '0;
    sts.del_oob  = pos_r >= count_ext;
    sts.at_pos   = idx_ext == pos_r;
    sts.at_last  = idx_r == (count_r - CW'(1));
    sts.scan_end = idx_r >= count_r;
    sts.cmp_vld  = cmp_vld_r;
    sts.hit      = cmp_vld_r && (rdata_r == val_r);
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.set_idx) begin
      case (cmd.idx_sel)
        IDX_ZERO: idx_nxt = '0;
        IDX_POS:  idx_nxt = CW'(pos_r);
        IDX_TOP:  idx_nxt = count_r - CW'(1);
        default:  idx_nxt = idx_r;
      endcase
    end else if (cmd.rd_en) begin
      idx_nxt = is_ins ? (idx_r - CW'(1)) : (idx_r + CW'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // entry memory: one registered read, one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[idx_r[AW-1:0]];
    end
    if (pend_r) begin
      mem[pend_addr_r] <= rdata_r;
    end else if (cmd.wr_val) begin
      mem[pos_r[AW-1:0]] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pend_r     <= 1'b0;
      pend_cap_r <= 1'b0;
      cmp_vld_r  <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      pend_r     <= cmd.rd_en && (is_ins || (is_del && !sts.at_pos));
      pend_cap_r <= cmd.rd_en && is_del && sts.at_pos;
      cmp_vld_r  <= cmd.rd_en && (op_r == OP_SEARCH);
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_addr_r <= is_ins ? AW'(idx_r + CW'(1)) : AW'(idx_r - CW'(1));
    cmp_addr_r  <= idx_r[AW-1:0];
    if (cmd.load) begin
      op_r      <= in_op;
      val_r     <= in_value;
      pos_r     <= pos_load;
      removed_r <= '0;
      found_r   <= '0;
    end else begin
      if (pend_cap_r) begin
        removed_r <= rdata_r;
      end
      if (cmd.set_found) begin
        found_r <= POS_W'(cmp_addr_r);
      end
    end
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
  end

  assign out_status        = st_r;
  assign out_removed_value = removed_r;
  assign out_found_index   = found_r;
  assign out_length        = count_ext;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_wr_collide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_val |-> !pend_r)
    else $error("value write collides with a pending move");

  a_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert into a full list");

  a_cap_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cap_r && !cmd.load) |=> (removed_r == $past(rdata_r)))
    else $error("removed value not captured");
`endif

endmodule

`default_nettype wire

/* sv/ols_ctrl.sv */
// Controller of the ordered list store: request sequencing state machine.
`default_nettype none

module ols_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ols_pkg::ols_sts_t sts,
  output ols_pkg::ols_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import ols_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_INS_SHIFT = 4'd2;
  localparam logic [3:0] S_INS_LAST  = 4'd3;
  localparam logic [3:0] S_INS_VAL   = 4'd4;
  localparam logic [3:0] S_DEL_SHIFT = 4'd5;
  localparam logic [3:0] S_DEL_LAST  = 4'd6;
  localparam logic [3:0] S_SRCH      = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.op)
          OP_INS_POS, OP_INS_TAIL: begin
            if (sts.ins_oob) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_OOB;
              state_nxt  = S_DONE;
            end else if (sts.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
              state_nxt  = S_DONE;
            end else if (sts.at_tail) begin
              state_nxt = S_INS_VAL;
            end else begin
              cmd.set_idx = 1'b1;
              cmd.idx_sel = IDX_TOP;
              state_nxt   = S_INS_SHIFT;
            end
          end
          OP_DEL_POS, OP_DEL_TAIL: begin
            if (sts.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_EMPTY;
              state_nxt  = S_DONE;
            end else if (sts.del_oob) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_OOB;
              state_nxt  = S_DONE;
            end else begin
              cmd.set_idx = 1'b1;
              cmd.idx_sel = IDX_POS;
              state_nxt   = S_DEL_SHIFT;
            end
          end
          OP_SEARCH: begin
            cmd.set_idx = 1'b1;
            cmd.idx_sel = IDX_ZERO;
            state_nxt   = S_SRCH;
          end
          default: begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_OK;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_INS_SHIFT: begin
        cmd.rd_en = 1'b1;
        if (sts.at_pos) begin
          state_nxt = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        state_nxt = S_INS_VAL;
      end
      S_INS_VAL: begin
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.st      = ST_OK;
        state_nxt   = S_DONE;
      end
      S_DEL_SHIFT: begin
        cmd.rd_en = 1'b1;
        if (sts.at_last) begin
          state_nxt = S_DEL_LAST;
        end
      end
      S_DEL_LAST: begin
        cmd.cnt_dec = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.st      = ST_OK;
        state_nxt   = S_DONE;
      end
      S_SRCH: begin
        if (sts.hit) begin
          cmd.set_found = 1'b1;
          cmd.set_st    = 1'b1;
          cmd.st        = ST_OK;
          state_nxt     = S_DONE;
        end else if (sts.scan_end && !sts.cmp_vld) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_en = !sts.scan_end;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the ordered list store.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ols_pkg::*;

  // Op codes the block must treat as no-ops.
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  // Give the watchdog plenty of room over the longest request plus the
  // longest sender gap.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 2 * (OLS_CAPACITY + 5);
  localparam int MAX_GAP        = 30;
  localparam int MAX_BURST      = 24;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] removed;
    logic [POS_W-1:0]        found;
    logic [LEN_W-1:0]        len;
  } list_answer_t;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    start       = 1'b0;
  logic [OP_W-1:0]         in_op       = '0;
  logic signed [VAL_W-1:0] in_value    = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    busy;
  logic                    out_valid;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_removed_value;
  logic [POS_W-1:0]        out_found_index;
  logic [LEN_W-1:0]        out_length;

  // Shadow copy of the list, updated as each item is accepted.
  logic signed [VAL_W-1:0] shadow_list [OLS_CAPACITY];
  int                      shadow_len  = 0;

  list_answer_t answer_q [$];
  int           burst_left  = 0;
  int           fail_count  = 0;
  int           idle_cycles = 0;

  always #2 clk = ~clk;

  ordered_list_store i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_found_index   (out_found_index),
    .out_length        (out_length)
  );

  // Apply one request to the shadow list and return the answer it should give.
  function automatic list_answer_t list_apply(input logic [OP_W-1:0] op,
                                              input logic signed [VAL_W-1:0] value,
                                              input logic [POS_W-1:0] pos);
    list_answer_t ans;
    int           target;
    bit           hit;
    ans = '0;
    hit = 1'b0;
    case (op)
      OP_INS_POS, OP_INS_TAIL: begin
        target = (op == OP_INS_TAIL) ? shadow_len : int'(pos);
        // Bounds check wins over the full check.
        if (target > shadow_len) begin
          ans.status = ST_OOB;
        end else if (shadow_len >= OLS_CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > target; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[target] = value;
          shadow_len++;
          ans.status = ST_OK;
        end
      end
      OP_DEL_POS, OP_DEL_TAIL: begin
        target = (op == OP_DEL_TAIL) ? shadow_len - 1 : int'(pos);
        if (shadow_len == 0) begin
          ans.status = ST_EMPTY;
        end else if (target >= shadow_len) begin
          ans.status = ST_OOB;
        end else begin
          ans.removed = shadow_list[target];
          for (int i = target; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          ans.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        ans.status = ST_NOTFOUND;
        for (int i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_list[i] == value) begin
            hit        = 1'b1;
            ans.status = ST_OK;
            ans.found  = POS_W'(i);
          end
        end
      end
      default: ;
    endcase
    ans.len = LEN_W'(shadow_len);
    return ans;
  endfunction

  // Values: some repeat what the list holds (duplicates), some are corners.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2 && shadow_len > 0) return shadow_list[$urandom_range(0, shadow_len - 1)];
    if (r < 4) begin
      case ($urandom_range(0, 4))
        0:       return 32'sd0;
        1:       return -32'sd1;
        2:       return 32'sd1;
        3:       return 32'sh8000_0000;
        default: return 32'sh7fff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // Search keys: mostly present in the list, the rest likely misses.
  function automatic logic signed [VAL_W-1:0] pick_key();
    if (shadow_len > 0 && $urandom_range(0, 9) < 6)
      return shadow_list[$urandom_range(0, shadow_len - 1)];
    return pick_value();
  endfunction

  // Present one item and hold it until the block takes it. Called and
  // returning at a falling edge; start stays high between them, so back-to-back
  // items are taken as soon as the block goes idle.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [VAL_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      // End of burst: drop start for a random gap, then pick the next burst.
      gap = $urandom_range(1, MAX_GAP);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, MAX_BURST);
    end
    burst_left--;
    start       <= 1'b1;
    in_op       <= op;
    in_value    <= value;
    in_position <= pos;
    do @(posedge clk); while (busy);
    // Taken at this edge: record what it should answer.
    answer_q.push_back(list_apply(op, value, pos));
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding answer has come back.
  task automatic wait_for_answers();
    start <= 1'b0;
    @(negedge clk);
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  // Extremes of value and position, every op, each rejection path but a full list.
  task automatic test_corner_requests();
    send_item(OP_DEL_POS, $urandom, 8'd255);          // delete from empty list
    send_item(OP_DEL_TAIL, $urandom, 8'd0);           // delete tail from empty list
    send_item(OP_SEARCH, 32'sd0, 8'd0);               // search of empty list
    send_item(OP_INS_POS, 32'sd5, 8'd1);              // insert past the end
    send_item(OP_INS_POS, 32'sh8000_0000, 8'd0);      // head insert, most negative
    send_item(OP_INS_TAIL, 32'sh7fff_ffff, 8'd200);   // tail insert ignores position
    send_item(OP_INS_POS, -32'sd1, 8'd1);             // middle insert
    send_item(OP_INS_POS, -32'sd1, 8'd3);             // insert at length, duplicate value
    send_item(OP_SEARCH, -32'sd1, 8'd0);              // first of two matches
    send_item(OP_SEARCH, 32'sh7fff_ffff, 8'd0);
    send_item(OP_SEARCH, 32'sd0, 8'd0);               // missing key
    send_item(OP_INS_POS, 32'sd9, 8'd255);            // insert far past the end
    send_item(OP_DEL_POS, $urandom, 8'd4);            // delete at length
    send_item(OP_RSVD_5, $urandom, 8'hff);
    send_item(OP_RSVD_6, $urandom, 8'h00);
    send_item(OP_RSVD_7, $urandom, 8'ha5);
    send_item(OP_DEL_POS, $urandom, 8'd1);
    send_item(OP_DEL_POS, $urandom, 8'd0);            // delete head
    send_item(OP_DEL_TAIL, $urandom, 8'd77);
    send_item(OP_DEL_TAIL, $urandom, 8'd0);           // list becomes empty
    send_item(OP_SEARCH, 32'sh7fff_ffff, 8'd0);
  endtask

  // Fill to capacity with random inserts, hit the full and bounds rejections,
  // probe with searches, then drain with random deletes.
  task automatic test_fill_and_drain(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      while (shadow_len < OLS_CAPACITY) begin
        if ($urandom_range(0, 1))
          send_item(OP_INS_POS, pick_value(), POS_W'($urandom_range(0, shadow_len)));
        else
          send_item(OP_INS_TAIL, pick_value(), POS_W'($urandom));
      end
      send_item(OP_INS_POS, pick_value(), POS_W'($urandom_range(0, shadow_len)));
      send_item(OP_INS_TAIL, pick_value(), POS_W'($urandom));
      send_item(OP_INS_POS, pick_value(), POS_W'($urandom_range(shadow_len + 1, 255)));
      send_item(OP_SEARCH, shadow_list[OLS_CAPACITY - 1], 8'd0);
      send_item(OP_SEARCH, pick_key(), 8'd0);
      send_item(OP_SEARCH, pick_key(), 8'd0);
      send_item(OP_DEL_POS, $urandom, POS_W'($urandom_range(shadow_len, 255)));
      while (shadow_len > 0) begin
        if ($urandom_range(0, 1))
          send_item(OP_DEL_POS, $urandom, POS_W'($urandom_range(0, shadow_len - 1)));
        else
          send_item(OP_DEL_TAIL, $urandom, POS_W'($urandom));
      end
      send_item(OP_DEL_TAIL, $urandom, POS_W'($urandom));
      send_item(OP_DEL_POS, $urandom, POS_W'($urandom));
      send_item(OP_SEARCH, pick_key(), POS_W'($urandom));
    end
  endtask

  // Weighted random requests; the mix drifts between growing and shrinking
  // so the length wanders over its whole range.
  task automatic test_random_mix(input int count);
    int r;
    int ins_w;
    bit grow;
    grow = 1'b1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) grow = !grow;
      ins_w = grow ? 50 : 20;
      r = $urandom_range(0, 99);
      if (r < ins_w) begin
        if ($urandom_range(0, 2) != 0)
          send_item(OP_INS_POS, pick_value(), POS_W'($urandom_range(0, shadow_len)));
        else
          send_item(OP_INS_TAIL, pick_value(), POS_W'($urandom));
      end else if (r < 70) begin
        if (shadow_len > 0 && $urandom_range(0, 2) != 0)
          send_item(OP_DEL_POS, $urandom, POS_W'($urandom_range(0, shadow_len - 1)));
        else
          send_item(OP_DEL_TAIL, $urandom, POS_W'($urandom));
      end else if (r < 90) begin
        send_item(OP_SEARCH, pick_key(), POS_W'($urandom));
      end else if (r < 94) begin
        // Position out of bounds, anywhere up to the top of the field.
        if ($urandom_range(0, 1))
          send_item(OP_INS_POS, pick_value(), POS_W'($urandom_range(shadow_len + 1, 255)));
        else
          send_item(OP_DEL_POS, $urandom, POS_W'($urandom_range(shadow_len, 255)));
      end else if (r < 97) begin
        send_item(OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7)), $urandom, POS_W'($urandom));
      end else begin
        send_item(OP_W'($urandom), $urandom, POS_W'($urandom));
      end
    end
  endtask

  task automatic report_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Every strobed result is taken at this edge; match it against the oldest
  // outstanding answer.
  always @(posedge clk) begin : check_answers
    list_answer_t want;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d length %0d",
                 $time, out_status, out_length);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        report_field("status", want.status, out_status);
        report_field("removed_value", want.removed, out_removed_value);
        report_field("found_index", want.found, out_found_index);
        report_field("length", want.len, out_length);
      end
    end
  end

  // Count cycles with no item taken and no result shown; stop a hung run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d answers outstanding", $time, answer_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_corner_requests();
    test_fill_and_drain(4);
    wait_for_answers();
    test_random_mix(865);
    // Release the input and let the last answers drain out.
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* ordered_list_store.f */
sv/ols_pkg.sv
sv/ols_dp.sv
sv/ols_ctrl.sv
sv/ordered_list_store.sv
verif/tb.sv
